### rtl/per_client_rate_limiter_core_defines.svh
// ----------------------------------------------------------------------------
// per_client_rate_limiter_core_defines
// assertion macros for the rate limiter checker
// ----------------------------------------------------------------------------
`ifndef PER_CLIENT_RATE_LIMITER_CORE_DEFINES_SVH
`define PER_CLIENT_RATE_LIMITER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define PRL_ASSERT_NOW(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("prl assertion failed");

// next-cycle implication, off during reset
`define PRL_ASSERT_NEXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("prl assertion failed");

`endif

### rtl/prl_pkg.sv
// ----------------------------------------------------------------------------
// prl_pkg
// shared types, codes and constants of the per-client rate limiter
// ----------------------------------------------------------------------------
package prl_pkg;

	localparam int CLIENTS_DEF     = 16;
	localparam int STAMP_SLOTS_DEF = 16;

	localparam logic [31:0] IDLE_MS   = 32'd300000;
	localparam logic [31:0] WINDOW_MS = 32'd1000;

	localparam int PADDR_W = 5;
	localparam int REG_W   = 3;

	// request operations
	localparam logic [2:0] OP_CHECK_RATE  = 3'd0;
	localparam logic [2:0] OP_RECORD      = 3'd1;
	localparam logic [2:0] OP_FAIL        = 3'd2;
	localparam logic [2:0] OP_CHECK_BLOCK = 3'd3;
	localparam logic [2:0] OP_SWEEP       = 3'd4;

	// register indexes
	localparam logic [REG_W-1:0] REG_MAX_REQUESTS = 3'd0;
	localparam logic [REG_W-1:0] REG_MAX_FAILURES = 3'd1;
	localparam logic [REG_W-1:0] REG_BLOCK_TIME   = 3'd2;
	localparam logic [REG_W-1:0] REG_ALLOWED_NET  = 3'd3;
	localparam logic [REG_W-1:0] REG_ALLOWED_MASK = 3'd4;

	localparam logic [4:0]  MAX_REQUESTS_RST = 5'd10;
	localparam logic [7:0]  MAX_FAILURES_RST = 8'd5;
	localparam logic [31:0] BLOCK_TIME_RST   = 32'd300000;
	localparam logic [31:0] ALLOWED_NET_RST  = 32'hC0A8_0000;
	localparam logic [31:0] ALLOWED_MASK_RST = 32'hFFFF_0000;

	typedef struct packed {
		logic [4:0]  max_requests;
		logic [7:0]  max_failures;
		logic [31:0] block_time;
		logic [31:0] allowed_net;
		logic [31:0] allowed_mask;
	} cfg_t;

	// one client table row, stamp count kept beside it
	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] last_seen;
		logic [7:0]  fail_count;
		logic [31:0] blocked_until;
	} entry_t;

endpackage

### rtl/prl_if.sv
// ----------------------------------------------------------------------------
// prl_if
// valid/ready channels for request and response beats
// ----------------------------------------------------------------------------
interface prl_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [31:0] client_ip;
	logic [31:0] now_ms;

	modport source (output valid, output req_type, output client_ip, output now_ms,
		input ready);
	modport sink (input valid, input req_type, input client_ip, input now_ms,
		output ready);
endinterface

interface prl_rsp_if;
	logic valid;
	logic ready;
	logic deny;
	logic table_full;

	modport source (output valid, output deny, output table_full, input ready);
	modport sink (input valid, input deny, input table_full, output ready);
endinterface

### rtl/prl_ram.sv
// ----------------------------------------------------------------------------
// prl_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module prl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/prl_cfg.sv
// ----------------------------------------------------------------------------
// prl_cfg
// apb register file for limits, block time and whitelist subnet
// ----------------------------------------------------------------------------
module prl_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [prl_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output prl_pkg::cfg_t               cfg
);

	prl_pkg::cfg_t            cfg_q;
	logic [prl_pkg::REG_W-1:0] idx;
	logic                     wr;

	assign idx    = paddr[prl_pkg::PADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_requests <= prl_pkg::MAX_REQUESTS_RST;
			cfg_q.max_failures <= prl_pkg::MAX_FAILURES_RST;
			cfg_q.block_time   <= prl_pkg::BLOCK_TIME_RST;
			cfg_q.allowed_net  <= prl_pkg::ALLOWED_NET_RST;
			cfg_q.allowed_mask <= prl_pkg::ALLOWED_MASK_RST;
		end else if (wr) begin
			unique case (idx)
				prl_pkg::REG_MAX_REQUESTS: cfg_q.max_requests <= pwdata[4:0];
				prl_pkg::REG_MAX_FAILURES: cfg_q.max_failures <= pwdata[7:0];
				prl_pkg::REG_BLOCK_TIME:   cfg_q.block_time   <= pwdata;
				prl_pkg::REG_ALLOWED_NET:  cfg_q.allowed_net  <= pwdata;
				prl_pkg::REG_ALLOWED_MASK: cfg_q.allowed_mask <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			prl_pkg::REG_MAX_REQUESTS: prdata = {27'd0, cfg_q.max_requests};
			prl_pkg::REG_MAX_FAILURES: prdata = {24'd0, cfg_q.max_failures};
			prl_pkg::REG_BLOCK_TIME:   prdata = cfg_q.block_time;
			prl_pkg::REG_ALLOWED_NET:  prdata = cfg_q.allowed_net;
			prl_pkg::REG_ALLOWED_MASK: prdata = cfg_q.allowed_mask;
			default:                   prdata = 32'd0;
		endcase
	end

endmodule

### rtl/per_client_rate_limiter_core.sv
// ----------------------------------------------------------------------------
// per_client_rate_limiter_core
// sliding-window-log rate limiter with a per-client table and stamp logs
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  req     | in  | valid/ready            | req_type, client_ip, now_ms
//  rsp     | out | valid/ready            | deny, table_full
//  apb     | in  | psel/penable, pready=1 | paddr, pwdata, prdata
//
//  a request beat scans the whole client table, one entry per cycle through the
//  single read port of the entry ram, and on a purge or shift also walks the
//  stamp log
//  req.ready is high only while the sequencer idles; the response register
//  lets a new beat in while the last answer still waits on rsp.ready
//  arst_n clears the control state, valid bits, last sweep time and registers
module per_client_rate_limiter_core #(
	parameter int CLIENTS     = prl_pkg::CLIENTS_DEF,
	parameter int STAMP_SLOTS = prl_pkg::STAMP_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	prl_req_if.sink                     req,
	prl_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [prl_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int IDX_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
	localparam int SL_W  = (STAMP_SLOTS > 1) ? $clog2(STAMP_SLOTS) : 1;
	localparam int CNT_W = $clog2(STAMP_SLOTS + 1);
	localparam int EW    = $bits(prl_pkg::entry_t) + CNT_W;
	localparam logic [IDX_W:0]   CLIENTS_N = (IDX_W+1)'(CLIENTS);
	localparam logic [CNT_W-1:0] SLOTS_N   = CNT_W'(STAMP_SLOTS);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_SCAN    = 7'b0000010,
		S_DECIDE  = 7'b0000100,
		S_COMPACT = 7'b0001000,
		S_APPEND  = 7'b0010000,
		S_WB      = 7'b0100000,
		S_DONE    = 7'b1000000
	} state_t;

	prl_pkg::cfg_t cfg;

	state_t             state_q;
	logic [2:0]         op_q;
	logic [31:0]        ip_q;
	logic [31:0]        now_q;
	logic               wl_q;
	logic               sweep_go_q;
	logic [31:0]        last_sweep_q;
	logic [CLIENTS-1:0] valid_q;

	// table scan
	logic [IDX_W:0]   scan_q;
	logic             rv_q;
	logic [IDX_W-1:0] ridx_q;
	logic             hit_q;
	logic [IDX_W-1:0] hidx_q;
	logic             free_q;
	logic [IDX_W-1:0] fidx_q;
	prl_pkg::entry_t  row_q;
	logic [CNT_W-1:0] cnt_q;

	// stamp log compaction
	logic [CNT_W-1:0] rk_q;
	logic             pv_q;
	logic [CNT_W-1:0] kept_q;
	logic [CNT_W-1:0] lim_q;
	logic             keep_all_q;

	logic res_deny_q;
	logic res_full_q;
	logic ovalid_q;
	logic odeny_q;
	logic ofull_q;

	logic                  accept;
	logic                  e_we;
	logic [EW-1:0]         e_rdata;
	prl_pkg::entry_t       e_row;
	logic [CNT_W-1:0]      e_cnt;
	logic                  s_we;
	logic [SL_W-1:0]       s_wslot;
	logic [31:0]           s_wdata;
	logic [31:0]           s_rdata;
	logic                  keep;
	logic                  is_hit;
	logic                  have;
	prl_pkg::entry_t       eff_row;
	logic [CNT_W-1:0]      eff_cnt;
	logic [IDX_W-1:0]      eff_idx;
	logic                  blocked_now;
	logic [7:0]            fail_inc;

	prl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// client table: address, last seen, failures, deadline and stamp count
	prl_ram #(.WIDTH(EW), .DEPTH(1 << IDX_W)) u_entry_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (hidx_q),
		.wdata ({row_q, cnt_q}),
		.raddr (scan_q[IDX_W-1:0]),
		.rdata (e_rdata)
	);

	// stamp logs, one row of slots per client
	prl_ram #(.WIDTH(32), .DEPTH(1 << (IDX_W + SL_W))) u_stamp_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr ({hidx_q, s_wslot}),
		.wdata (s_wdata),
		.raddr ({hidx_q, rk_q[SL_W-1:0]}),
		.rdata (s_rdata)
	);

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid      = ovalid_q;
	assign rsp.deny       = odeny_q;
	assign rsp.table_full = ofull_q;

	assign e_row = prl_pkg::entry_t'(e_rdata[EW-1:CNT_W]);
	assign e_cnt = e_rdata[CNT_W-1:0];
	assign is_hit = valid_q[ridx_q] && (e_row.addr == ip_q);
	assign e_we = (state_q == S_WB);

	// a stamp survives a purge while its age is inside the window
	assign keep = keep_all_q || ((now_q - s_rdata) <= prl_pkg::WINDOW_MS);

	always_comb begin
		s_we    = 1'b0;
		s_wslot = kept_q[SL_W-1:0];
		s_wdata = s_rdata;
		if (state_q == S_COMPACT) begin
			s_we = pv_q && keep;
		end else if (state_q == S_APPEND) begin
			s_we    = 1'b1;
			s_wslot = cnt_q[SL_W-1:0];
			s_wdata = now_q;
		end
	end

	// existing row, or a fresh one in the lowest free slot
	always_comb begin
		have        = hit_q || free_q;
		eff_row     = row_q;
		eff_cnt     = cnt_q;
		eff_idx     = hidx_q;
		if (!hit_q) begin
			eff_row      = '0;
			eff_row.addr = ip_q;
			eff_cnt      = '0;
			eff_idx      = fidx_q;
		end
		blocked_now = row_q.blocked_until > now_q;
		fail_inc    = eff_row.fail_count + 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			last_sweep_q <= '0;
			ovalid_q     <= 1'b0;
			scan_q       <= '0;
			rv_q         <= 1'b0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			pv_q         <= 1'b0;
			op_q         <= '0;
			wl_q         <= 1'b0;
			sweep_go_q   <= 1'b0;
			keep_all_q   <= 1'b0;
		end else begin
			if (ovalid_q && rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q   <= req.req_type;
						ip_q   <= req.client_ip;
						now_q  <= req.now_ms;
						wl_q   <= (req.client_ip & cfg.allowed_mask) ==
							(cfg.allowed_net & cfg.allowed_mask);
						sweep_go_q <= (req.req_type == prl_pkg::OP_SWEEP) &&
							((req.now_ms - last_sweep_q) > prl_pkg::IDLE_MS);
						scan_q  <= '0;
						rv_q    <= 1'b0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// one read issued and one row compared per cycle
					if (scan_q != CLIENTS_N) begin
						rv_q   <= 1'b1;
						ridx_q <= scan_q[IDX_W-1:0];
						scan_q <= scan_q + 1'b1;
					end else begin
						rv_q <= 1'b0;
					end
					if (rv_q) begin
						if (is_hit) begin
							hit_q  <= 1'b1;
							hidx_q <= ridx_q;
							row_q  <= e_row;
							cnt_q  <= e_cnt;
						end
						if (!free_q && !valid_q[ridx_q]) begin
							free_q <= 1'b1;
							fidx_q <= ridx_q;
						end
						// idle clients drop out during a due sweep
						if (sweep_go_q && valid_q[ridx_q] &&
							((now_q - e_row.last_seen) > prl_pkg::IDLE_MS)) begin
							valid_q[ridx_q] <= 1'b0;
						end
						if (scan_q == CLIENTS_N) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					res_deny_q <= 1'b0;
					res_full_q <= 1'b0;
					state_q    <= S_DONE;
					rk_q       <= '0;
					kept_q     <= '0;
					pv_q       <= 1'b0;
					if (op_q == prl_pkg::OP_CHECK_RATE) begin
						if (!wl_q && hit_q) begin
							if (blocked_now) begin
								res_deny_q <= 1'b1;
							end else begin
								keep_all_q <= 1'b0;
								lim_q      <= cnt_q;
								state_q    <= S_COMPACT;
							end
						end
					end else if (op_q == prl_pkg::OP_RECORD) begin
						if (!have) begin
							res_full_q <= 1'b1;
						end else begin
							valid_q[eff_idx] <= 1'b1;
							row_q  <= eff_row;
							cnt_q  <= eff_cnt;
							hidx_q <= eff_idx;
							if (eff_cnt == SLOTS_N) begin
								// full log: shift out the oldest stamp
								keep_all_q <= 1'b1;
								rk_q       <= CNT_W'(1);
								lim_q      <= SLOTS_N;
								state_q    <= S_COMPACT;
							end else begin
								state_q <= S_APPEND;
							end
						end
					end else if (op_q == prl_pkg::OP_FAIL) begin
						if (!wl_q) begin
							if (!have) begin
								res_full_q <= 1'b1;
							end else begin
								valid_q[eff_idx] <= 1'b1;
								row_q  <= eff_row;
								cnt_q  <= eff_cnt;
								hidx_q <= eff_idx;
								if (fail_inc >= cfg.max_failures) begin
									row_q.fail_count    <= 8'd0;
									row_q.blocked_until <= now_q + cfg.block_time;
									res_deny_q          <= 1'b1;
								end else begin
									row_q.fail_count <= fail_inc;
								end
								state_q <= S_WB;
							end
						end
					end else if (op_q == prl_pkg::OP_CHECK_BLOCK) begin
						res_deny_q <= !wl_q && hit_q && blocked_now;
					end else if (op_q == prl_pkg::OP_SWEEP) begin
						if (sweep_go_q) begin
							last_sweep_q <= now_q;
						end
					end
				end
				S_COMPACT: begin
					// read slot rk, write survivors down to slot kept
					if (pv_q && keep) begin
						kept_q <= kept_q + 1'b1;
					end
					if (rk_q != lim_q) begin
						pv_q <= 1'b1;
						rk_q <= rk_q + 1'b1;
					end else begin
						pv_q <= 1'b0;
					end
					if (rk_q == lim_q && !pv_q) begin
						cnt_q <= kept_q;
						if (keep_all_q) begin
							state_q <= S_APPEND;
						end else begin
							res_deny_q <= 8'(kept_q) >= 8'(cfg.max_requests);
							state_q    <= S_WB;
						end
					end
				end
				S_APPEND: begin
					cnt_q           <= cnt_q + 1'b1;
					row_q.last_seen <= now_q;
					state_q         <= S_WB;
				end
				S_WB: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!ovalid_q || rsp.ready) begin
						ovalid_q <= 1'b1;
						odeny_q  <= res_deny_q;
						ofull_q  <= res_full_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/prl_checker.sv
// ----------------------------------------------------------------------------
// prl_checker
// port-level checks on the rate limiter, bound to the top level
// ----------------------------------------------------------------------------
`include "per_client_rate_limiter_core_defines.svh"

module prl_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic deny,
	input logic table_full,
	input logic pready
);

	// the cycle after an accepted beat finds the sequencer busy
	`PRL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// a stalled response holds
	`PRL_ASSERT_NEXT(a_rsp_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(deny) && $stable(table_full))

	// a full table never comes with a deny
	`PRL_ASSERT_NOW(a_full_no_deny, clk, arst_n, out_valid, !(deny && table_full))

	// the register port never waits
	`PRL_ASSERT_NOW(a_pready, clk, arst_n, 1'b1, pready)

endmodule

bind per_client_rate_limiter_core prl_checker u_prl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.deny       (rsp.deny),
	.table_full (rsp.table_full),
	.pready     (pready)
);
